@@ design/pcp_pkg.sv @@
// shared types and constants for the plotter command parser
// no dependencies; imported by every design file
package pcp_pkg;

    // ascii characters the parser acts on
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_D     = 8'h44;

    // result kinds
    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [2:0] {
        CMD_IN    = 3'd0,
        CMD_SP    = 3'd1,
        CMD_PU    = 3'd2,
        CMD_PD    = 3'd3,
        CMD_OTHER = 3'd4
    } t_command;

    // where in the current command the next byte lands
    typedef enum logic [1:0] {
        POS_OP1  = 2'd0,
        POS_OP2  = 2'd1,
        POS_ARG1 = 2'd2,
        POS_REST = 2'd3
    } t_pos;

    // everything of a result except its coordinates
    typedef struct packed {
        logic       kind;
        t_command   command;
        logic [7:0] op_first;
        logic [7:0] op_second;
        logic [3:0] pen;
        logic       last;
    } t_meta;

endpackage

@@ design/pcp_parser.sv @@
// parser state and the per-beat decode of one text byte into up to two results
// depends on pcp_pkg
module pcp_parser import pcp_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output logic [1:0]            o_push,
    output t_meta                 o_meta0,
    output logic [COORD_BITS-1:0] o_x0,
    output logic [COORD_BITS-1:0] o_y0,
    output t_meta                 o_meta1
);

    localparam logic [COORD_BITS-1:0] HALF = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS+3:0] HALF_EXT = {4'b0000, HALF};

    t_pos                  r_pos, n_pos;
    logic [7:0]            r_first, n_first;
    logic [7:0]            r_second, n_second;
    t_command              r_cmd, n_cmd;
    logic [3:0]            r_pen, n_pen;
    logic [COORD_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_val_ok, n_val_ok;
    logic                  r_has_digit, n_has_digit;
    logic                  r_started, n_started;
    logic                  r_parity, n_parity;
    logic [COORD_BITS-1:0] r_pending_x, n_pending_x;

    logic                  moves;
    logic                  is_digit;
    logic [COORD_BITS-1:0] end_val;
    logic [COORD_BITS+3:0] acc_ext;
    logic [COORD_BITS+3:0] acc_next;
    t_meta                 pair_meta;
    t_meta                 end_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_OP1;
            r_first     <= '0;
            r_second    <= '0;
            r_cmd       <= CMD_OTHER;
            r_pen       <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_val_ok    <= 1'b0;
            r_has_digit <= 1'b0;
            r_started   <= 1'b0;
            r_parity    <= 1'b0;
            r_pending_x <= '0;
        end else begin
            r_pos       <= n_pos;
            r_first     <= n_first;
            r_second    <= n_second;
            r_cmd       <= n_cmd;
            r_pen       <= n_pen;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_val_ok    <= n_val_ok;
            r_has_digit <= n_has_digit;
            r_started   <= n_started;
            r_parity    <= n_parity;
            r_pending_x <= n_pending_x;
        end
    end

    assign moves    = (r_cmd == CMD_PU) || (r_cmd == CMD_PD);
    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);

    // value being read, as it stands when its delimiter arrives
    always_comb begin
        end_val = '0;
        if (r_val_ok && r_has_digit) begin
            if (r_neg) begin
                if (r_acc <= HALF) begin
                    end_val = '0 - r_acc;
                end
            end else if (r_acc < HALF) begin
                end_val = r_acc;
            end
        end
    end

    // times ten plus digit, clamped just above the range
    assign acc_ext  = {4'b0000, r_acc};
    assign acc_next = (acc_ext << 3) + (acc_ext << 1)
                    + {{COORD_BITS{1'b0}}, i_byte[3:0]};

    always_comb begin
        pair_meta           = '0;
        pair_meta.kind      = KIND_PAIR;
        pair_meta.command   = r_cmd;
        pair_meta.op_first  = r_first;
        pair_meta.op_second = r_second;
        end_meta            = pair_meta;
        end_meta.kind       = KIND_END;
        end_meta.pen        = (r_cmd == CMD_SP) ? r_pen : 4'd0;
        end_meta.last       = 1'b1;
    end

    always_comb begin
        n_pos       = r_pos;
        n_first     = r_first;
        n_second    = r_second;
        n_cmd       = r_cmd;
        n_pen       = r_pen;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_val_ok    = r_val_ok;
        n_has_digit = r_has_digit;
        n_started   = r_started;
        n_parity    = r_parity;
        n_pending_x = r_pending_x;
        o_push      = 2'd0;
        o_meta0     = '0;
        o_meta1     = '0;
        o_x0        = '0;
        o_y0        = '0;

        if (i_step && (i_byte != CH_LF)) begin
            if (i_byte == CH_SEMI) begin
                if (moves && (r_pos == POS_ARG1 || r_pos == POS_REST) && r_parity) begin
                    // closing y value completes a pair before the end record
                    o_meta0 = pair_meta;
                    o_x0    = r_pending_x;
                    o_y0    = end_val;
                    o_meta1 = end_meta;
                    o_push  = 2'd2;
                end else begin
                    o_meta0 = end_meta;
                    o_push  = 2'd1;
                end
                n_pos       = POS_OP1;
                n_first     = '0;
                n_second    = '0;
                n_cmd       = CMD_OTHER;
                n_pen       = '0;
                n_acc       = '0;
                n_neg       = 1'b0;
                n_val_ok    = 1'b0;
                n_has_digit = 1'b0;
                n_started   = 1'b0;
                n_parity    = 1'b0;
                n_pending_x = '0;
            end else begin
                case (r_pos)
                    POS_OP1: begin
                        n_first = i_byte;
                        n_pos   = POS_OP2;
                    end
                    POS_OP2: begin
                        n_second = i_byte;
                        n_pos    = POS_ARG1;
                        if (r_first == CH_I && i_byte == CH_N) begin
                            n_cmd = CMD_IN;
                        end else if (r_first == CH_S && i_byte == CH_P) begin
                            n_cmd = CMD_SP;
                        end else if (r_first == CH_P && i_byte == CH_U) begin
                            n_cmd = CMD_PU;
                        end else if (r_first == CH_P && i_byte == CH_D) begin
                            n_cmd = CMD_PD;
                        end else begin
                            n_cmd = CMD_OTHER;
                        end
                        n_acc       = '0;
                        n_neg       = 1'b0;
                        n_val_ok    = 1'b1;
                        n_has_digit = 1'b0;
                        n_started   = 1'b0;
                        n_parity    = 1'b0;
                    end
                    default: begin
                        if (r_pos == POS_ARG1) begin
                            n_pos = POS_REST;
                            if (r_cmd == CMD_SP && is_digit) begin
                                n_pen = i_byte[3:0];
                            end
                        end
                        if (moves) begin
                            if (i_byte == CH_COMMA) begin
                                n_acc       = '0;
                                n_neg       = 1'b0;
                                n_val_ok    = 1'b1;
                                n_has_digit = 1'b0;
                                n_started   = 1'b0;
                                if (!r_parity) begin
                                    n_pending_x = end_val;
                                    n_parity    = 1'b1;
                                end else begin
                                    o_meta0      = pair_meta;
                                    o_meta0.last = 1'b1;
                                    o_x0         = r_pending_x;
                                    o_y0         = end_val;
                                    o_push       = 2'd1;
                                    n_parity     = 1'b0;
                                end
                            end else begin
                                n_started = 1'b1;
                                if (i_byte == CH_MINUS || i_byte == CH_PLUS) begin
                                    if (r_started) begin
                                        n_val_ok = 1'b0;
                                    end else begin
                                        n_neg = (i_byte == CH_MINUS);
                                    end
                                end else if (is_digit) begin
                                    n_has_digit = 1'b1;
                                    if (acc_next > HALF_EXT) begin
                                        n_acc = HALF + 1'b1;
                                    end else begin
                                        n_acc = acc_next[COORD_BITS-1:0];
                                    end
                                end else begin
                                    n_val_ok = 1'b0;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

@@ design/pcp_out_fifo.sv @@
// small result queue: takes up to two entries a beat, gives one
// depends on pcp_pkg for its geometry
module pcp_out_fifo import pcp_pkg::*; #(
    parameter int WIDTH = 73
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push,
    input  logic [WIDTH-1:0] i_data0,
    input  logic [WIDTH-1:0] i_data1,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [FIFO_PTR_W-1:0] r_rd, n_rd;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // room for the worst case of two results from one beat
    assign o_space = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + i_push;
        n_rd    = r_rd + {{(FIFO_PTR_W-1){1'b0}}, pop};
        n_count = r_count + {1'b0, i_push} - {{(FIFO_CNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + FIFO_PTR_W'(1)] <= i_data1;
        end
    end

endmodule

@@ design/plotter_command_parser.sv @@
// plotter command parser: each input beat passes the input register, then is parsed
// into a four-entry result queue that drives the outputs
// throughput one text byte per cycle while the queue has room for two results;
// results leave at one per cycle while i_ready is high, so a ';' that closes a pair yields two
// synchronous active-low reset clears parser state, input register and queue
// depends on pcp_pkg, pcp_parser, pcp_out_fifo
module plotter_command_parser import pcp_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_text_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_kind,
    output logic [2:0]                   o_command,
    output logic [7:0]                   o_opcode_first,
    output logic [7:0]                   o_opcode_second,
    output logic [3:0]                   o_pen_number,
    output logic signed [COORD_BITS-1:0] o_coord_x,
    output logic signed [COORD_BITS-1:0] o_coord_y,
    output logic                         o_last
);

    localparam int META_W = $bits(t_meta);
    localparam int ENTRY_W = META_W + 2 * COORD_BITS;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  space;
    logic                  step;
    logic [1:0]            push;
    t_meta                 meta0;
    t_meta                 meta1;
    t_meta                 meta_out;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [ENTRY_W-1:0]    entry0;
    logic [ENTRY_W-1:0]    entry1;
    logic [ENTRY_W-1:0]    entry_out;

    assign step    = r_in_valid && space;
    assign o_ready = !r_in_valid || space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    pcp_parser #(
        .COORD_BITS(COORD_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_push  (push),
        .o_meta0 (meta0),
        .o_x0    (x0),
        .o_y0    (y0),
        .o_meta1 (meta1)
    );

    // second result of a beat is always an end record, coordinates zero
    assign entry0 = {meta0, x0, y0};
    assign entry1 = {meta1, {(2 * COORD_BITS){1'b0}}};

    pcp_out_fifo #(
        .WIDTH(ENTRY_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (entry0),
        .i_data1 (entry1),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (entry_out)
    );

    assign meta_out        = t_meta'(entry_out[ENTRY_W-1 -: META_W]);
    assign o_kind          = meta_out.kind;
    assign o_command       = meta_out.command;
    assign o_opcode_first  = meta_out.op_first;
    assign o_opcode_second = meta_out.op_second;
    assign o_pen_number    = meta_out.pen;
    assign o_last          = meta_out.last;
    assign o_coord_x       = entry_out[2*COORD_BITS-1 -: COORD_BITS];
    assign o_coord_y       = entry_out[COORD_BITS-1:0];

endmodule
